FILE: sv/saa_pkg.sv
`timescale 1ns / 1ps
package saa_pkg;

  localparam int ITEM_W = 12;
  localparam int IDX_W  = 3;
  localparam int POS_W  = 11;

  localparam int DEF_ATLAS_SIDE  = 2048;
  localparam int DEF_MAX_ATLASES = 8;

  localparam logic [ITEM_W-1:0] ENTRY_LIMIT_RST = 12'd512;

  typedef enum logic [1:0] {
    STATUS_PLACED = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_FULL   = 2'd2
  } status_t;

  // Outcome flags of one shelf step
  typedef struct packed {
    logic wrap;
    logic fit;
  } step_flags_t;

endpackage

FILE: sv/saa_if.sv
`timescale 1ns / 1ps
interface saa_in_if import saa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ITEM_W-1:0] item_width;
  logic [ITEM_W-1:0] item_height;

  modport source (output valid, item_width, item_height, input ready);
  modport sink   (input valid, item_width, item_height, output ready);
endinterface

interface saa_out_if import saa_pkg::*; ();
  logic             valid;
  logic             ready;
  status_t          status;
  logic [IDX_W-1:0] atlas_index;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  modport source (output valid, status, atlas_index, pos_x, pos_y, input ready);
  modport sink   (input valid, status, atlas_index, pos_x, pos_y, output ready);
endinterface

interface saa_cfg_if import saa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ITEM_W-1:0] entry_limit;

  modport source (output valid, entry_limit, input ready);
  modport sink   (input valid, entry_limit, output ready);
endinterface

FILE: sv/saa_shelf_unit.sv
`timescale 1ns / 1ps
module saa_shelf_unit import saa_pkg::*; #(
  parameter int ATLAS_SIDE = DEF_ATLAS_SIDE,
  parameter int CW         = $clog2(ATLAS_SIDE + 1)
) (
  input  logic [CW-1:0] cur_i,
  input  logic [CW-1:0] top_i,
  input  logic [CW-1:0] hgt_i,
  input  logic [CW-1:0] w_i,
  input  logic [CW-1:0] h_i,
  output step_flags_t   flags_o,
  output logic [CW-1:0] pos_x_o,
  output logic [CW-1:0] pos_y_o,
  output logic [CW-1:0] cur_o,
  output logic [CW-1:0] top_o,
  output logic [CW-1:0] hgt_o
);

  localparam logic [CW:0] SIDE = (CW + 1)'(ATLAS_SIDE);

  logic [CW:0]   cur_end;
  logic [CW:0]   top_wrap;
  logic [CW:0]   bot_end;
  logic [CW-1:0] cur_a;
  logic [CW-1:0] top_a;
  logic [CW-1:0] hgt_a;

  always_comb begin
    // Close the shelf when the width overruns the row
    cur_end       = {1'b0, cur_i} + {1'b0, w_i};
    flags_o.wrap  = cur_end > SIDE;
    top_wrap      = {1'b0, top_i} + {1'b0, hgt_i};
    cur_a         = flags_o.wrap ? '0 : cur_i;
    top_a         = flags_o.wrap ? top_wrap[CW-1:0] : top_i;
    hgt_a         = flags_o.wrap ? '0 : hgt_i;
    bot_end       = {1'b0, top_a} + {1'b0, h_i};
    flags_o.fit   = bot_end <= SIDE;
    pos_x_o       = cur_a;
    pos_y_o       = top_a;
    top_o         = top_a;
    cur_o         = flags_o.fit ? cur_a + w_i : cur_a;
    hgt_o         = (flags_o.fit && (h_i > hgt_a)) ? h_i : hgt_a;
  end

endmodule

FILE: sv/saa_shelf_store.sv
`timescale 1ns / 1ps
module saa_shelf_store import saa_pkg::*; #(
  parameter int ATLAS_SIDE  = DEF_ATLAS_SIDE,
  parameter int MAX_ATLASES = DEF_MAX_ATLASES,
  parameter int CW          = $clog2(ATLAS_SIDE + 1),
  parameter int AW          = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1
) (
  input  logic          clk,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [CW-1:0] cur_i,
  input  logic [CW-1:0] top_i,
  input  logic [CW-1:0] hgt_i,
  output logic [CW-1:0] cur_o,
  output logic [CW-1:0] top_o,
  output logic [CW-1:0] hgt_o
);

  // Entries are cleared when an atlas opens, so no reset is needed
  logic [CW-1:0] cur_mem [MAX_ATLASES];
  logic [CW-1:0] top_mem [MAX_ATLASES];
  logic [CW-1:0] hgt_mem [MAX_ATLASES];

  always_ff @(posedge clk) begin
    if (we_i) begin
      cur_mem[addr_i] <= cur_i;
      top_mem[addr_i] <= top_i;
      hgt_mem[addr_i] <= hgt_i;
    end
  end

  assign cur_o = cur_mem[addr_i];
  assign top_o = top_mem[addr_i];
  assign hgt_o = hgt_mem[addr_i];

endmodule

FILE: sv/shelf_atlas_allocator_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake      Payload
// in_ch    sink       valid/ready    item_width, item_height
// out_ch   source     valid/ready    status, atlas_index, pos_x, pos_y
// cfg_ch   sink       valid/ready    entry_limit (always ready)
//
// An item is accepted, then the shared shelf unit visits the open atlases
// (newest first), one per search step, and opens a new atlas when none takes
// the item; with every atlas open and none taking it, the result is full.
// A size reject shows its result the cycle after accept.
// Reset (rst_n, synchronous) closes every atlas and restores entry_limit.
// in_ch.ready stays low from accept until out_ch has handed over the result.
module shelf_atlas_allocator_top import saa_pkg::*; #(
  parameter int ATLAS_SIDE  = DEF_ATLAS_SIDE,
  parameter int MAX_ATLASES = DEF_MAX_ATLASES
) (
  input  logic       clk,
  input  logic       rst_n,
  saa_in_if.sink     in_ch,
  saa_out_if.source  out_ch,
  saa_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(ATLAS_SIDE + 1);
  localparam int AW = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
  localparam int NW = $clog2(MAX_ATLASES + 1);
  localparam logic [ITEM_W:0] SIDE_ITEM = (ITEM_W + 1)'(ATLAS_SIDE);
  localparam logic [NW-1:0]   MAX_N     = NW'(MAX_ATLASES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_OUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [ITEM_W-1:0] limit_r, limit_nxt;
  logic [NW-1:0]     open_r, open_nxt;
  logic [NW-1:0]     k_r, k_nxt;
  logic              fresh_r, fresh_nxt;
  logic [CW-1:0]     w_r, w_nxt;
  logic [CW-1:0]     h_r, h_nxt;
  status_t           status_r, status_nxt;
  logic [IDX_W-1:0]  aidx_r, aidx_nxt;
  logic [POS_W-1:0]  px_r, px_nxt;
  logic [POS_W-1:0]  py_r, py_nxt;

  logic [NW-1:0]     k_dec;
  logic [AW-1:0]     idx;
  logic              reject;
  logic [CW-1:0]     rd_cur, rd_top, rd_hgt;
  logic [CW-1:0]     u_cur, u_top, u_hgt;
  logic [CW-1:0]     n_cur, n_top, n_hgt;
  logic [CW-1:0]     pos_x, pos_y;
  step_flags_t       flags;
  logic              st_we;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign cfg_ch.ready    = 1'b1;
  assign out_ch.valid    = (state_r == S_OUT);
  assign out_ch.status   = status_r;
  assign out_ch.atlas_index = aidx_r;
  assign out_ch.pos_x    = px_r;
  assign out_ch.pos_y    = py_r;

  // Visit atlases from the newest down; a fresh atlas sits at the open count
  assign k_dec = k_r - NW'(1);
  assign idx   = fresh_r ? open_r[AW-1:0] : k_dec[AW-1:0];
  assign st_we = (state_r == S_SEARCH);

  // A fresh atlas enters the unit cleared, so it always takes the item
  assign u_cur = fresh_r ? '0 : rd_cur;
  assign u_top = fresh_r ? '0 : rd_top;
  assign u_hgt = fresh_r ? '0 : rd_hgt;

  assign reject = (in_ch.item_width == '0) || (in_ch.item_height == '0) ||
                  (in_ch.item_width > limit_r) || (in_ch.item_height > limit_r) ||
                  ({1'b0, in_ch.item_width} > SIDE_ITEM) ||
                  ({1'b0, in_ch.item_height} > SIDE_ITEM);

  saa_shelf_store #(
    .ATLAS_SIDE  (ATLAS_SIDE),
    .MAX_ATLASES (MAX_ATLASES),
    .CW          (CW),
    .AW          (AW)
  ) u_store (
    .clk    (clk),
    .we_i   (st_we),
    .addr_i (idx),
    .cur_i  (n_cur),
    .top_i  (n_top),
    .hgt_i  (n_hgt),
    .cur_o  (rd_cur),
    .top_o  (rd_top),
    .hgt_o  (rd_hgt)
  );

  saa_shelf_unit #(
    .ATLAS_SIDE (ATLAS_SIDE),
    .CW         (CW)
  ) u_unit (
    .cur_i   (u_cur),
    .top_i   (u_top),
    .hgt_i   (u_hgt),
    .w_i     (w_r),
    .h_i     (h_r),
    .flags_o (flags),
    .pos_x_o (pos_x),
    .pos_y_o (pos_y),
    .cur_o   (n_cur),
    .top_o   (n_top),
    .hgt_o   (n_hgt)
  );

  always_comb begin
    state_nxt  = state_r;
    limit_nxt  = limit_r;
    open_nxt   = open_r;
    k_nxt      = k_r;
    fresh_nxt  = fresh_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    status_nxt = status_r;
    aidx_nxt   = aidx_r;
    px_nxt     = px_r;
    py_nxt     = py_r;

    if (cfg_ch.valid) begin
      limit_nxt = cfg_ch.entry_limit;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          // Sides are at most the atlas side once past the reject check
          w_nxt      = CW'(in_ch.item_width);
          h_nxt      = CW'(in_ch.item_height);
          k_nxt      = open_r;
          fresh_nxt  = (open_r == '0);
          status_nxt = STATUS_REJECT;
          aidx_nxt   = '0;
          px_nxt     = '0;
          py_nxt     = '0;
          state_nxt  = reject ? S_OUT : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (flags.fit) begin
          // Place here; narrow result fields keep their low bits
          status_nxt = STATUS_PLACED;
          aidx_nxt   = IDX_W'(idx);
          px_nxt     = POS_W'(pos_x);
          py_nxt     = POS_W'(pos_y);
          state_nxt  = S_OUT;
          if (fresh_r) begin
            open_nxt = open_r + NW'(1);
          end
        end else begin
          // Wrap is written back; go to the next older atlas, or past the oldest open a fresh one or report full
          k_nxt = k_dec;
          if (k_r == NW'(1)) begin
            if (open_r == MAX_N) begin
              status_nxt = STATUS_FULL;
              state_nxt  = S_OUT;
            end else begin
              fresh_nxt = 1'b1;
            end
          end
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          fresh_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= ENTRY_LIMIT_RST;
      open_r  <= '0;
      k_r     <= '0;
      fresh_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      limit_r <= limit_nxt;
      open_r  <= open_nxt;
      k_r     <= k_nxt;
      fresh_r <= fresh_nxt;
    end
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    status_r <= status_nxt;
    aidx_r   <= aidx_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
  end

  // Open count never passes the atlas bound
  a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= MAX_N)
    else $error("open atlas count beyond bound");

  // Atlases only ever open, one per item at most
  a_open_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (open_r != $past(open_r)) |-> (open_r == $past(open_r) + NW'(1)))
    else $error("open atlas count moved by other than one");

  // An unplaced result carries no position
  a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != STATUS_PLACED)) |->
      (out_ch.atlas_index == '0 && out_ch.pos_x == '0 && out_ch.pos_y == '0))
    else $error("unplaced result with nonzero position");

  // A fresh atlas always takes the item in the same step
  a_fresh_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && fresh_r) |=> (state_r == S_OUT && status_r == STATUS_PLACED))
    else $error("fresh atlas failed to place item");

endmodule

FILE: tb/tb_shelf_atlas_allocator_top.sv
`timescale 1ns / 1ps
module tb_shelf_atlas_allocator_top;
  import saa_pkg::*;

  localparam int SIDE         = DEF_ATLAS_SIDE;
  localparam int NUM_ATLAS    = DEF_MAX_ATLASES;
  // No item may take longer than the long receiver hold plus a full search.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 150;
  localparam int PRINT_CAP    = 50;

  typedef struct packed {
    logic [ITEM_W-1:0] w;
    logic [ITEM_W-1:0] h;
  } rect_t;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] atlas;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n;

  saa_in_if  in_ch ();
  saa_out_if out_ch ();
  saa_cfg_if cfg_ch ();

  shelf_atlas_allocator_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  // Shadow of the shelf state, one entry per atlas.
  logic [ITEM_W-1:0] shelf_x    [NUM_ATLAS];
  logic [ITEM_W-1:0] shelf_top  [NUM_ATLAS];
  logic [ITEM_W-1:0] shelf_tall [NUM_ATLAS];
  logic [3:0]        atlases_used;
  logic [ITEM_W-1:0] limit_shadow;

  rect_t      rect_backlog [$];
  placement_t expected_placements [$];

  int error_count  = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  bit in_fire      = 1'b0;

  // Sender burst shaping
  int burst_left = 0;
  int gap_left   = 0;
  rect_t next_rect;

  // Receiver stall shaping
  logic [15:0] stall_pattern = 16'hFFFF;
  int pattern_age  = 0;
  int hold_left    = 0;
  int next_hold_at = 300;

  task automatic note_error(input string msg);
    if (error_count < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic int clip(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // Put the rectangle at the current cursor of atlas a, then advance the shelf.
  function automatic placement_t shelve(input int a, input rect_t r);
    placement_t res;
    res.status = STATUS_PLACED;
    res.atlas  = a[IDX_W-1:0];
    res.x      = shelf_x[a][POS_W-1:0];
    res.y      = shelf_top[a][POS_W-1:0];
    shelf_x[a] = shelf_x[a] + r.w;
    if (r.h > shelf_tall[a]) shelf_tall[a] = r.h;
    return res;
  endfunction

  // Work out the answer to one rectangle and update the shelf shadow.
  function automatic placement_t place_rect(input rect_t r);
    placement_t res;
    int n;
    res.status = STATUS_REJECT;
    res.atlas  = '0;
    res.x      = '0;
    res.y      = '0;
    if (r.w == 0 || r.h == 0 || r.w > limit_shadow || r.h > limit_shadow ||
        r.w > SIDE || r.h > SIDE)
      return res;
    n = clip(int'(atlases_used), NUM_ATLAS);
    // Newest atlas first; a wrap sticks even when the atlas is skipped.
    for (int a = n - 1; a >= 0; a--) begin
      if (int'(shelf_x[a]) + int'(r.w) > SIDE) begin
        shelf_x[a]    = '0;
        shelf_top[a]  = shelf_top[a] + shelf_tall[a];
        shelf_tall[a] = '0;
      end
      if (int'(shelf_top[a]) + int'(r.h) <= SIDE) return shelve(a, r);
    end
    if (n >= NUM_ATLAS) begin
      res.status = STATUS_FULL;
      return res;
    end
    shelf_x[n]    = '0;
    shelf_top[n]  = '0;
    shelf_tall[n] = '0;
    atlases_used  = 4'(n + 1);
    return shelve(n, r);
  endfunction

  // Pick one side near the limit: the smallest, just below it, the limit itself, or just past it.
  function automatic logic [ITEM_W-1:0] boundary_side(input int lim);
    case ($urandom_range(0, 3))
      0: return ITEM_W'(1);
      1: return ITEM_W'(lim);
      2: return ITEM_W'(lim + 1);
      default: return ITEM_W'((lim > 1) ? lim - 1 : 1);
    endcase
  endfunction

  // Mostly well-formed rectangles, biased small so the atlases fill slowly.
  function automatic rect_t random_rect(input int limit);
    rect_t r;
    int lim;
    int pick;
    lim  = (limit < 1) ? 1 : clip(limit, SIDE);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.w = ITEM_W'($urandom_range(1, clip(lim, 64)));
      r.h = ITEM_W'($urandom_range(1, clip(lim, 64)));
    end else if (pick < 72) begin
      r.w = ITEM_W'($urandom_range(1, clip(lim, 512)));
      r.h = ITEM_W'($urandom_range(1, clip(lim, 512)));
    end else if (pick < 84) begin
      r.w = ITEM_W'($urandom_range(1, lim));
      r.h = ITEM_W'($urandom_range(1, lim));
    end else if (pick < 90) begin
      r.w = boundary_side(lim);
      r.h = boundary_side(lim);
    end else if (pick < 95) begin
      r.w = $urandom_range(0, 1) ? '0 : ITEM_W'($urandom_range(0, lim));
      r.h = (r.w != 0) ? '0 : ITEM_W'($urandom_range(0, lim));
    end else begin
      r.w = ITEM_W'($urandom_range(0, 4095));
      r.h = ITEM_W'($urandom_range(0, 4095));
    end
    return r;
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 9))
      0, 1, 2: return 0;
      8:       return $urandom_range(7, 15);
      9:       return $urandom_range(20, 40);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  task automatic add_rect(input int w, input int h);
    rect_t r;
    r.w = ITEM_W'(w);
    r.h = ITEM_W'(h);
    rect_backlog.push_back(r);
  endtask

  // Hold the sender until every queued item has gone through and been answered.
  task automatic wait_drained();
    while (rect_backlog.size() != 0 || in_ch.valid || expected_placements.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_limit(input int value);
    @(negedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.entry_limit <= ITEM_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sample every handshake at the rising edge: predict on input, check on output.
  always @(posedge clk) begin
    in_fire = 1'b0;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_shadow = cfg_ch.entry_limit;
        quiet_cycles = 0;
      end
      if (in_ch.valid && in_ch.ready) begin
        in_fire = 1'b1;
        expected_placements.push_back(place_rect({in_ch.item_width, in_ch.item_height}));
        quiet_cycles = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        results_seen++;
        if (expected_placements.size() == 0) begin
          note_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          placement_t want;
          want = expected_placements.pop_front();
          if (out_ch.status !== want.status)
            note_error($sformatf("result %0d status %0d, expected %0d",
                                 results_seen, out_ch.status, want.status));
          if (out_ch.atlas_index !== want.atlas)
            note_error($sformatf("result %0d atlas_index %0d, expected %0d",
                                 results_seen, out_ch.atlas_index, want.atlas));
          if (out_ch.pos_x !== want.x)
            note_error($sformatf("result %0d pos_x %0d, expected %0d",
                                 results_seen, out_ch.pos_x, want.x));
          if (out_ch.pos_y !== want.y)
            note_error($sformatf("result %0d pos_y %0d, expected %0d",
                                 results_seen, out_ch.pos_y, want.y));
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Drive the input at the falling edge: hold an item until it is taken,
  // then offer the next one or sit out a gap.
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (rect_backlog.size() != 0) begin
        next_rect = rect_backlog.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.item_width  <= next_rect.w;
        in_ch.item_height <= next_rect.h;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = pick_gap();
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: a rotating stall pattern, redrawn whenever its age count runs out, and
  // now and then a long hold so the block backs up and stalls its input.
  always @(negedge clk) begin
    if (results_seen >= next_hold_at && hold_left == 0) begin
      hold_left    = LONG_HOLD;
      next_hold_at = next_hold_at + 900;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = 31;
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom) | 16'h0001;
          2: stall_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
          default: stall_pattern = 16'($urandom) | 16'($urandom);
        endcase
      end else begin
        pattern_age--;
      end
      out_ch.ready <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  initial begin
    int phase_limits [6];
    int phase_items  [6];
    int cur_limit;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.item_width   = '0;
    in_ch.item_height  = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.entry_limit = '0;
    limit_shadow       = ENTRY_LIMIT_RST;
    atlases_used       = '0;
    for (int a = 0; a < NUM_ATLAS; a++) begin
      shelf_x[a]    = '0;
      shelf_top[a]  = '0;
      shelf_tall[a] = '0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset limit: zero sides, sides past the limit, then fill one shelf
    // row and force a wrap.
    add_rect(0, 5);
    add_rect(5, 0);
    add_rect(0, 0);
    add_rect(513, 1);
    add_rect(1, 513);
    add_rect(4095, 4095);
    add_rect(1, 1);
    repeat (3) add_rect(512, 512);
    add_rect(511, 100);
    add_rect(2, 2);
    wait_drained();

    // Smallest limit: only a unit square gets through.
    write_limit(1);
    add_rect(1, 1);
    add_rect(2, 1);
    add_rect(1, 2);
    wait_drained();

    // Limit past the atlas side: the atlas itself bounds the rectangle.
    write_limit(4095);
    add_rect(2048, 1);
    add_rect(1, 2048);
    add_rect(2049, 5);
    add_rect(5, 2049);
    add_rect(4095, 4095);
    add_rect(2048, 2048);
    wait_drained();

    // Zero limit rejects everything.
    write_limit(0);
    add_rect(1, 1);
    wait_drained();

    // Random phases; large limits late so the atlases run full.
    phase_limits = '{64, 0, 512, 2048, 4095, 0};
    phase_items  = '{400, 300, 300, 400, 200, 200};
    phase_limits[1] = $urandom_range(2, 2047);
    phase_limits[5] = $urandom_range(1, 2048);
    for (int p = 0; p < 6; p++) begin
      cur_limit = phase_limits[p];
      write_limit(cur_limit);
      for (int i = 0; i < phase_items[p]; i++) rect_backlog.push_back(random_rect(cur_limit));
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
